// ===== src/bdc_pkg.sv =====
// shared constants and bit-level helpers for the ble receive dewhitening and crc check
package bdc_pkg;

    localparam logic [23:0] CrcSeed    = 24'h555555;
    localparam logic [23:0] CrcPoly    = 24'h00065B;
    localparam logic [7:0]  WhitenTap  = 8'h11;

    // bit-reverse one byte
    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = v[i];
        end
        return r;
    endfunction

    // whitening seed from the channel number, 7-bit register form
    function automatic logic [6:0] whiten_seed(input logic [5:0] chan);
        logic [7:0] s8;
        s8 = rev8({2'b00, chan}) | 8'h02;
        return s8[7:1];
    endfunction

    // one byte through the whitening lfsr: {next register, clear byte}
    function automatic logic [14:0] dewhiten(input logic [6:0] lfsr, input logic [7:0] raw);
        logic [7:0] w;
        logic [7:0] d;
        w = {lfsr, 1'b0};
        d = raw;
        for (int k = 0; k < 8; k++) begin
            if (w[7]) begin
                w    = w ^ WhitenTap;
                d[k] = ~d[k];
            end
            w = {w[6:0], 1'b0};
        end
        return {w[7:1], d};
    endfunction

    // one byte through the crc-24, lsb first
    function automatic logic [23:0] crc_step(input logic [23:0] crc, input logic [7:0] d);
        logic [23:0] c;
        logic        top;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            top = c[23];
            c   = {c[22:0], 1'b0};
            if (top != d[k]) begin
                c = c ^ CrcPoly;
            end
        end
        return c;
    endfunction

endpackage

// ===== src/bdc_in_if.sv =====
// input byte channel
interface bdc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;
    logic       start_of_packet;

    modport source (output valid, output raw_byte, output start_of_packet, input ready);
    modport sink   (input valid, input raw_byte, input start_of_packet, output ready);
endinterface

// ===== src/bdc_out_if.sv =====
// result byte channel
interface bdc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] clear_byte;
    logic       last;
    logic       crc_ok;
    logic       length_error;

    modport source (output valid, output clear_byte, output last, output crc_ok,
                    output length_error, input ready);
    modport sink   (input valid, input clear_byte, input last, input crc_ok,
                    input length_error, output ready);
endinterface

// ===== src/bdc_cfg_if.sv =====
// channel register write channel
interface bdc_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] channel_index;

    modport source (output valid, output channel_index, input ready);
    modport sink   (input valid, input channel_index, output ready);
endinterface

// ===== src/ble_rx_dewhiten_crc_check_unit.sv =====
// ble receive path: dewhitening, crc-24 over header and payload, crc compare
//
//  port    dir   carries
//  i_in    in    raw_byte[7:0], start_of_packet
//  o_out   out   clear_byte[7:0], last, crc_ok, length_error
//  i_cfg   in    channel_index[5:0]
//
// one byte per cycle unless output stalls: input register, one pass of 8 unrolled lfsr and crc steps, result register
// a taken byte is held in the input register, then in the result register once the output is free
// synchronous active-low reset: idle phase, channel 37, both registers empty
// a stalled output holds its byte and the input register, input ready drops only then
// bytes outside a packet are taken and dropped with no result
module ble_rx_dewhiten_crc_check_unit #(
    parameter int unsigned MaxPayload = 255
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bdc_in_if.sink       i_in,
    bdc_out_if.source    o_out,
    bdc_cfg_if.sink      i_cfg
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_HDR1    = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_CRC     = 2'd3;

    logic [5:0]  r_chan;

    logic        r_in_vld;
    logic [7:0]  r_in_raw;
    logic        r_in_sop;

    logic [1:0]  r_phase, n_phase;
    logic [6:0]  r_lfsr, n_lfsr;
    logic [23:0] r_crc, n_crc;
    logic [7:0]  r_left, n_left;
    logic [1:0]  r_crc_pos, n_crc_pos;
    logic        r_mismatch, n_mismatch;

    logic        r_out_vld;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_ok;
    logic        r_out_lerr;

    logic        w_emit, w_last, w_ok, w_lerr;
    logic [7:0]  w_clear, w_expect;
    logic [14:0] w_dw;
    logic [6:0]  w_lfsr_in;
    logic [23:0] w_crc_new;
    logic        w_out_free, w_adv;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= 6'd37;
        end else if (i_cfg.valid) begin
            r_chan <= i_cfg.channel_index;
        end
    end

    // start reseeds before the byte is dewhitened
    assign w_lfsr_in = r_in_sop ? bdc_pkg::whiten_seed(r_chan) : r_lfsr;
    assign w_dw      = bdc_pkg::dewhiten(w_lfsr_in, r_in_raw);
    assign w_clear   = w_dw[7:0];
    assign w_crc_new = bdc_pkg::crc_step(r_in_sop ? bdc_pkg::CrcSeed : r_crc, w_clear);

    always_comb begin
        case (r_crc_pos)
            2'd0:    w_expect = bdc_pkg::rev8(r_crc[23:16]);
            2'd1:    w_expect = bdc_pkg::rev8(r_crc[15:8]);
            default: w_expect = bdc_pkg::rev8(r_crc[7:0]);
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_lfsr     = r_lfsr;
        n_crc      = r_crc;
        n_left     = r_left;
        n_crc_pos  = r_crc_pos;
        n_mismatch = r_mismatch;
        w_emit     = 1'b1;
        w_last     = 1'b0;
        w_ok       = 1'b0;
        w_lerr     = 1'b0;
        if (r_in_sop) begin
            n_lfsr     = w_dw[14:8];
            n_crc      = w_crc_new;
            n_left     = 8'd0;
            n_crc_pos  = 2'd0;
            n_mismatch = 1'b0;
            n_phase    = PH_HDR1;
        end else begin
            case (r_phase)
                PH_HDR1: begin
                    n_lfsr = w_dw[14:8];
                    n_crc  = w_crc_new;
                    if ({1'b0, w_clear} > 9'(MaxPayload)) begin
                        w_last  = 1'b1;
                        w_lerr  = 1'b1;
                        n_phase = PH_IDLE;
                    end else if (w_clear == 8'd0) begin
                        n_crc_pos  = 2'd0;
                        n_mismatch = 1'b0;
                        n_phase    = PH_CRC;
                    end else begin
                        n_left  = w_clear;
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_lfsr = w_dw[14:8];
                    n_crc  = w_crc_new;
                    n_left = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_crc_pos  = 2'd0;
                        n_mismatch = 1'b0;
                        n_phase    = PH_CRC;
                    end
                end
                PH_CRC: begin
                    n_lfsr     = w_dw[14:8];
                    n_mismatch = r_mismatch | (w_clear != w_expect);
                    if (r_crc_pos >= 2'd2) begin
                        w_last    = 1'b1;
                        w_ok      = !n_mismatch;
                        n_crc_pos = 2'd0;
                        n_phase   = PH_IDLE;
                    end else begin
                        n_crc_pos = r_crc_pos + 2'd1;
                    end
                end
                default: begin
                    w_emit = 1'b0;
                end
            endcase
        end
    end

    assign w_out_free = !r_out_vld || o_out.ready;
    // the held byte moves on unless it needs the output and the output is full
    assign w_adv      = r_in_vld && (!w_emit || w_out_free);
    assign i_in.ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_raw <= i_in.raw_byte;
            r_in_sop <= i_in.start_of_packet;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_lfsr     <= 7'd0;
            r_crc      <= bdc_pkg::CrcSeed;
            r_left     <= 8'd0;
            r_crc_pos  <= 2'd0;
            r_mismatch <= 1'b0;
        end else if (w_adv) begin
            r_phase    <= n_phase;
            r_lfsr     <= n_lfsr;
            r_crc      <= n_crc;
            r_left     <= n_left;
            r_crc_pos  <= n_crc_pos;
            r_mismatch <= n_mismatch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_adv && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_adv && w_emit) begin
            r_out_byte <= w_clear;
            r_out_last <= w_last;
            r_out_ok   <= w_ok;
            r_out_lerr <= w_lerr;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.clear_byte   = r_out_byte;
    assign o_out.last         = r_out_last;
    assign o_out.crc_ok       = r_out_ok;
    assign o_out.length_error = r_out_lerr;

    a_lerr_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_lerr) |-> r_out_last)
        else $error("length error result without last");

    a_ok_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_ok) |-> (r_out_last && !r_out_lerr))
        else $error("crc_ok set outside a final crc byte");

    a_crc_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CRC) |-> (r_crc_pos <= 2'd2))
        else $error("crc byte position out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> (!r_in_vld || w_adv))
        else $error("input register overwritten while held");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_vld && !r_in_vld && r_phase == PH_IDLE))
        else $error("registers not empty after reset");

endmodule

// ===== tb/tb_ble_rx_dewhiten_crc_check_unit.sv =====
// testbench for the ble receive dewhitening and crc-24 check unit
module tb_ble_rx_dewhiten_crc_check_unit;

    localparam int WatchLimit = 1000;
    localparam int RandItems  = 1800;
    localparam int CalmItems  = 200;
    localparam int DirRows    = 28;
    localparam int MaxPayload = 255;

    typedef enum logic [1:0] {RX_IDLE, RX_LEN, RX_BODY, RX_CRC} t_rx_phase;
    typedef enum logic [1:0] {B_RAW, B_CLEAR, B_CRC} t_byte_kind;

    typedef struct packed {
        logic [7:0] clear;
        logic       last;
        logic       crc_ok;
        logic       length_error;
    } t_rx_res;

    // flags are {last, crc_ok, length_error}
    typedef struct packed {
        t_byte_kind kind;
        logic       sop;
        logic [7:0] val;
        logic       tc;
        logic       tf;
        logic [2:0] flags;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    bdc_in_if  in_ch ();
    bdc_out_if out_ch ();
    bdc_cfg_if cfg_ch ();

    ble_rx_dewhiten_crc_check_unit #(
        .MaxPayload (MaxPayload)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // receiver state as the block should hold it
    t_rx_phase   rx_phase   = RX_IDLE;
    logic [5:0]  rx_chan    = 6'd37;
    logic [6:0]  rx_lfsr    = '0;
    logic [23:0] rx_crc     = bdc_pkg::CrcSeed;
    logic [7:0]  rx_left    = '0;
    logic [1:0]  rx_crc_pos = '0;
    logic        rx_bad     = 1'b0;

    // sender side: whitens clear bytes and builds crc fields
    logic [5:0]  cur_chan = 6'd37;
    logic [6:0]  tx_lfsr  = '0;
    logic [23:0] tx_crc   = bdc_pkg::CrcSeed;
    logic [1:0]  tx_pos   = '0;

    t_rx_res rx_bytes_q[$];

    // hand-typed expectation riding along with the byte in flight
    logic       drv_tc;
    logic       drv_tf;
    logic [7:0] drv_clear;
    logic [2:0] drv_flags;

    int n_err     = 0;
    int n_sent    = 0;
    int n_pkts    = 0;
    int n_phase   = 0;
    int retune_at = 0;
    int quiet     = 0;
    bit gaps_on   = 1'b1;

    t_stim_row dir_rows [DirRows] = '{
        // noise between packets, dropped
        '{B_RAW,   1'b0, 8'h00, 1'b0, 1'b0, 3'b000},
        '{B_RAW,   1'b0, 8'hFF, 1'b0, 1'b0, 3'b000},
        // zero length, good crc
        '{B_CLEAR, 1'b1, 8'h00, 1'b1, 1'b1, 3'b000},
        '{B_CLEAR, 1'b0, 8'h00, 1'b1, 1'b1, 3'b000},
        '{B_CRC,   1'b0, 8'h00, 1'b0, 1'b1, 3'b000},
        '{B_CRC,   1'b0, 8'h00, 1'b0, 1'b1, 3'b000},
        '{B_CRC,   1'b0, 8'h00, 1'b0, 1'b1, 3'b110},
        // two payload bytes at the extremes, good crc
        '{B_CLEAR, 1'b1, 8'hFF, 1'b1, 1'b1, 3'b000},
        '{B_CLEAR, 1'b0, 8'h02, 1'b1, 1'b1, 3'b000},
        '{B_CLEAR, 1'b0, 8'h00, 1'b1, 1'b1, 3'b000},
        '{B_CLEAR, 1'b0, 8'hFF, 1'b1, 1'b1, 3'b000},
        '{B_CRC,   1'b0, 8'h00, 1'b0, 1'b1, 3'b000},
        '{B_CRC,   1'b0, 8'h00, 1'b0, 1'b1, 3'b000},
        '{B_CRC,   1'b0, 8'h00, 1'b0, 1'b1, 3'b110},
        // first crc byte corrupted
        '{B_CLEAR, 1'b1, 8'h5A, 1'b1, 1'b1, 3'b000},
        '{B_CLEAR, 1'b0, 8'h01, 1'b1, 1'b1, 3'b000},
        '{B_CLEAR, 1'b0, 8'hA5, 1'b1, 1'b1, 3'b000},
        '{B_CRC,   1'b0, 8'h01, 1'b0, 1'b1, 3'b000},
        '{B_CRC,   1'b0, 8'h00, 1'b0, 1'b1, 3'b000},
        '{B_CRC,   1'b0, 8'h00, 1'b0, 1'b1, 3'b100},
        // packet cut short by a new start
        '{B_CLEAR, 1'b1, 8'h40, 1'b1, 1'b1, 3'b000},
        '{B_CLEAR, 1'b0, 8'h03, 1'b1, 1'b1, 3'b000},
        '{B_CLEAR, 1'b0, 8'h11, 1'b1, 1'b1, 3'b000},
        // last crc byte corrupted
        '{B_CLEAR, 1'b1, 8'h0C, 1'b1, 1'b1, 3'b000},
        '{B_CLEAR, 1'b0, 8'h00, 1'b1, 1'b1, 3'b000},
        '{B_CRC,   1'b0, 8'h00, 1'b0, 1'b1, 3'b000},
        '{B_CRC,   1'b0, 8'h00, 1'b0, 1'b1, 3'b000},
        '{B_CRC,   1'b0, 8'h80, 1'b0, 1'b1, 3'b100}
    };

    // 7-bit whitening register loaded from the channel: reversed channel bits, then a one
    function automatic logic [6:0] seed_of(input logic [5:0] c);
        return {c[0], c[1], c[2], c[3], c[4], c[5], 1'b1};
    endfunction

    // returns {next register, byte xor whitening}; the same step whitens and dewhitens
    function automatic logic [14:0] whiten_byte(input logic [6:0] s, input logic [7:0] b);
        logic fb;
        for (int k = 0; k < 8; k++) begin
            fb   = s[6];
            b[k] = b[k] ^ fb;
            s    = {s[5:0], fb} ^ {2'b00, fb, 4'b0000};
        end
        return {s, b};
    endfunction

    function automatic logic [23:0] crc_next(input logic [23:0] c, input logic [7:0] d);
        logic fb;
        for (int k = 0; k < 8; k++) begin
            fb = c[23] ^ d[k];
            c  = {c[22:0], 1'b0} ^ (fb ? bdc_pkg::CrcPoly : 24'h000000);
        end
        return c;
    endfunction

    // crc byte as it goes on air: high byte first, bits reversed
    function automatic logic [7:0] crc_field(input logic [23:0] c, input logic [1:0] pos);
        logic [7:0] b;
        logic [7:0] r;
        case (pos)
            2'd0: b = c[23:16];
            2'd1: b = c[15:8];
            default: b = c[7:0];
        endcase
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7 - i];
        end
        return r;
    endfunction

    task automatic track_rx_byte(input logic [7:0] raw, input logic sop,
                                 output bit has, output t_rx_res r);
        logic [14:0] w;
        logic [7:0]  want;
        r   = '0;
        has = 1'b1;
        if (sop) begin
            rx_lfsr    = seed_of(rx_chan);
            rx_crc     = bdc_pkg::CrcSeed;
            rx_left    = '0;
            rx_crc_pos = '0;
            rx_bad     = 1'b0;
            w          = whiten_byte(rx_lfsr, raw);
            rx_lfsr    = w[14:8];
            r.clear    = w[7:0];
            rx_crc     = crc_next(rx_crc, r.clear);
            rx_phase   = RX_LEN;
        end else begin
            case (rx_phase)
                RX_LEN: begin
                    w       = whiten_byte(rx_lfsr, raw);
                    rx_lfsr = w[14:8];
                    r.clear = w[7:0];
                    rx_crc  = crc_next(rx_crc, r.clear);
                    if ({1'b0, r.clear} > 9'(MaxPayload)) begin
                        r.last         = 1'b1;
                        r.length_error = 1'b1;
                        rx_phase       = RX_IDLE;
                    end else if (r.clear == 8'h00) begin
                        rx_crc_pos = '0;
                        rx_bad     = 1'b0;
                        rx_phase   = RX_CRC;
                    end else begin
                        rx_left  = r.clear;
                        rx_phase = RX_BODY;
                    end
                end
                RX_BODY: begin
                    w       = whiten_byte(rx_lfsr, raw);
                    rx_lfsr = w[14:8];
                    r.clear = w[7:0];
                    rx_crc  = crc_next(rx_crc, r.clear);
                    rx_left = rx_left - 8'd1;
                    if (rx_left == 8'd0) begin
                        rx_crc_pos = '0;
                        rx_bad     = 1'b0;
                        rx_phase   = RX_CRC;
                    end
                end
                RX_CRC: begin
                    want    = crc_field(rx_crc, rx_crc_pos);
                    w       = whiten_byte(rx_lfsr, raw);
                    rx_lfsr = w[14:8];
                    r.clear = w[7:0];
                    if (r.clear != want) begin
                        rx_bad = 1'b1;
                    end
                    if (rx_crc_pos >= 2'd2) begin
                        r.last     = 1'b1;
                        r.crc_ok   = ~rx_bad;
                        rx_crc_pos = '0;
                        rx_phase   = RX_IDLE;
                    end else begin
                        rx_crc_pos = rx_crc_pos + 2'd1;
                    end
                end
                default: begin
                    // dropped between packets
                    rx_phase = RX_IDLE;
                    has      = 1'b0;
                end
            endcase
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // output side: random back-pressure bursts
    initial begin
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (gaps_on && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_rx_res e;
        bit      has;
        if (i_rst_n) begin
            quiet = quiet + 1;
            if (cfg_ch.valid && cfg_ch.ready) begin
                rx_chan = cfg_ch.channel_index;
                quiet   = 0;
            end
            if (in_ch.valid && in_ch.ready) begin
                quiet = 0;
                track_rx_byte(in_ch.raw_byte, in_ch.start_of_packet, has, e);
                if (has) begin
                    if (drv_tc) begin
                        e.clear = drv_clear;
                    end
                    if (drv_tf) begin
                        {e.last, e.crc_ok, e.length_error} = drv_flags;
                    end
                    rx_bytes_q.push_back(e);
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                quiet = 0;
                if (rx_bytes_q.size() == 0) begin
                    $error("result with nothing expected: clear_byte %h last %b",
                           out_ch.clear_byte, out_ch.last);
                    n_err++;
                end else begin
                    e = rx_bytes_q.pop_front();
                    if (out_ch.clear_byte !== e.clear) begin
                        $error("clear_byte: expected %h, got %h", e.clear, out_ch.clear_byte);
                        n_err++;
                    end
                    if (out_ch.last !== e.last) begin
                        $error("last: expected %b, got %b", e.last, out_ch.last);
                        n_err++;
                    end
                    if (out_ch.crc_ok !== e.crc_ok) begin
                        $error("crc_ok: expected %b, got %b", e.crc_ok, out_ch.crc_ok);
                        n_err++;
                    end
                    if (out_ch.length_error !== e.length_error) begin
                        $error("length_error: expected %b, got %b",
                               e.length_error, out_ch.length_error);
                        n_err++;
                    end
                end
            end
            if (quiet >= WatchLimit) begin
                $display("tb_ble_rx_dewhiten_crc_check_unit: errors");
                $finish;
            end
        end
    end

    // drain the block, then write a new channel and start a new phase
    task automatic next_phase();
        logic [5:0] c;
        case (n_phase)
            0: c = 6'd0;
            1: c = 6'd39;
            2: c = 6'd63;
            default: c = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(40, 63))
                                                     : 6'($urandom_range(0, 39));
        endcase
        n_phase++;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (rx_bytes_q.size() != 0) @(posedge i_clk);
        // dropped bytes leave no result, give them time to leave the pipe
        repeat (4) @(posedge i_clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.channel_index <= c;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_chan = c;
        gaps_on  = ($urandom_range(0, 3) != 0);
        retune_at = n_sent + $urandom_range(100, 250);
        if (retune_at > RandItems - CalmItems) begin
            retune_at = 0;
        end
    endtask

    task automatic send_byte(input t_byte_kind kind, input logic sop, input logic [7:0] val,
                             input logic tc, input logic tf, input logic [2:0] flags);
        logic [14:0] w;
        logic [7:0]  raw;
        if (sop) begin
            tx_lfsr = seed_of(cur_chan);
            tx_crc  = bdc_pkg::CrcSeed;
            tx_pos  = '0;
        end
        case (kind)
            B_CLEAR: begin
                w       = whiten_byte(tx_lfsr, val);
                tx_lfsr = w[14:8];
                raw     = w[7:0];
                tx_crc  = crc_next(tx_crc, val);
            end
            B_CRC: begin
                w       = whiten_byte(tx_lfsr, crc_field(tx_crc, tx_pos) ^ val);
                tx_lfsr = w[14:8];
                raw     = w[7:0];
                tx_pos  = tx_pos + 2'd1;
            end
            default: raw = val;
        endcase
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.raw_byte        <= raw;
        in_ch.start_of_packet <= sop;
        drv_tc                <= tc;
        drv_tf                <= tf;
        drv_clear             <= val;
        drv_flags             <= flags;
        do @(posedge i_clk); while (!in_ch.ready);
        n_sent++;
        if (retune_at != 0 && n_sent >= retune_at) begin
            next_phase();
        end
    endtask

    task automatic send_packet();
        int         len;
        int         cut;
        int         bad_at;
        int         r;
        logic [7:0] bad_x;
        // stray bytes between packets, now and then one with a start flag
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                send_byte(B_RAW, ($urandom_range(0, 3) == 0), 8'($urandom), 1'b0, 1'b0, 3'b000);
            end
        end
        r = $urandom_range(0, 199);
        if (r < 2 || n_pkts == 3) begin
            len = 255;
        end else if (r < 20) begin
            len = $urandom_range(17, 80);
        end else begin
            len = $urandom_range(0, 16);
        end
        n_pkts++;
        cut    = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len + 2) : len + 3;
        bad_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : -1;
        bad_x  = 8'($urandom_range(1, 255));
        send_byte(B_CLEAR, 1'b1, 8'($urandom), 1'b0, 1'b0, 3'b000);
        send_byte(B_CLEAR, 1'b0, 8'(len), 1'b0, 1'b0, 3'b000);
        for (int k = 0; k < cut; k++) begin
            if (k < len) begin
                send_byte(B_CLEAR, 1'b0, 8'($urandom), 1'b0, 1'b0, 3'b000);
            end else begin
                send_byte(B_CRC, 1'b0, (k - len == bad_at) ? bad_x : 8'h00,
                          1'b0, 1'b0, 3'b000);
            end
        end
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.raw_byte        <= '0;
        in_ch.start_of_packet <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.channel_index  <= '0;
        drv_tc                <= 1'b0;
        drv_tf                <= 1'b0;
        drv_clear             <= '0;
        drv_flags             <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DirRows; i++) begin
            send_byte(dir_rows[i].kind, dir_rows[i].sop, dir_rows[i].val,
                      dir_rows[i].tc, dir_rows[i].tf, dir_rows[i].flags);
        end

        n_sent = 0;
        next_phase();
        while (n_sent < RandItems) begin
            if (n_sent >= RandItems - CalmItems) begin
                gaps_on = 1'b0;
            end
            send_packet();
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (rx_bytes_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_err == 0) begin
            $display("tb_ble_rx_dewhiten_crc_check_unit: clean");
        end else begin
            $display("tb_ble_rx_dewhiten_crc_check_unit: errors");
        end
        $finish;
    end

endmodule

// ===== ble_rx_dewhiten_crc_check_unit.f =====
src/bdc_pkg.sv
src/bdc_in_if.sv
src/bdc_out_if.sv
src/bdc_cfg_if.sv
src/ble_rx_dewhiten_crc_check_unit.sv
tb/tb_ble_rx_dewhiten_crc_check_unit.sv
